@@ src/fan_heater_thermal_controller_core_defines.svh @@
// assertion macros for the checker file
`ifndef FAN_HEATER_THERMAL_CONTROLLER_CORE_DEFINES_SVH
`define FAN_HEATER_THERMAL_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FHTC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FHTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fhtc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fhtc_pkg;

  localparam int PWM_MAX_DEF     = 1000;
  localparam int KICK_MIN        = 300;
  localparam int RAMP_START_DEF  = 25;
  localparam int RAMP_FULL_DEF   = 40;
  localparam int HEAT_TARGET_DEF = 25;
  localparam int OT_SET_DELTA    = 8;
  localparam int OT_CLR_DELTA    = 5;
  localparam int OT_SET_TICKS    = 5;
  localparam int OT_CLR_TICKS    = 5;
  localparam int SAMPLE_LAST     = 2;   // divider value on the refreshing tick
  localparam int RAMP_SPAN_MAX   = 254; // largest t - start inside the ramp
  localparam int PID_KP2         = 30;  // proportional gain in half units
  localparam int PID_KD_SHIFT    = 2;   // derivative gain 4 in half units

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int TEMP_W     = 8;
  localparam int LEVEL_W    = 10;
  localparam int CNT_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAN_TEMP_START = 3'd0,
    CFG_FAN_TEMP_FULL  = 3'd1,
    CFG_HEAT_TARGET    = 3'd2,
    CFG_FAN_ENABLE     = 3'd3,
    CFG_HEAT_ENABLE    = 3'd4,
    CFG_FORCE_FULL     = 3'd5
  } cfg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // input transfer, latch system_active, refresh held temp on every third load
    logic prot;      // over-temperature counters and latch
    logic prep;      // ramp product into divider, integral pre-sum
    logic div_step;  // one restoring division step
    logic finish;    // compute levels, commit state, load output register
  } fhtc_cmd_t;

  function automatic int pwm_width(input int pwm_max);
    return $clog2(pwm_max + 1);
  endfunction

  function automatic int div_width(input int pwm_max);
    return $clog2(RAMP_SPAN_MAX * pwm_max + 1);
  endfunction

  function automatic int sum_width(input int pwm_max);
    return $clog2(2 * pwm_max + 1);
  endfunction

endpackage

`default_nettype wire

@@ src/fhtc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fhtc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fhtc_pkg::TEMP_W-1:0]    sensor_temp_a;
  logic signed [fhtc_pkg::TEMP_W-1:0]    sensor_temp_b;
  logic                                  system_active;

  modport source (output valid, output sensor_temp_a, output sensor_temp_b,
                  output system_active, input ready);
  modport sink (input valid, input sensor_temp_a, input sensor_temp_b,
                input system_active, output ready);
endinterface

interface fhtc_out_if;
  logic                             valid;
  logic                             ready;
  logic [fhtc_pkg::LEVEL_W-1:0]     fan_level;
  logic [fhtc_pkg::LEVEL_W-1:0]     heater_level;
  logic                             over_temp;

  modport source (output valid, output fan_level, output heater_level,
                  output over_temp, input ready);
  modport sink (input valid, input fan_level, input heater_level,
                input over_temp, output ready);
endinterface

`default_nettype wire

@@ src/fhtc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fhtc_ctrl #(
  parameter int DIV_STEPS = 18
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  output fhtc_pkg::fhtc_cmd_t  cmd
);

  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROT,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  state_t              state_r;
  logic [STEP_W-1:0]   step_r;
  logic                in_ready_r;
  logic                out_valid_r;
  logic                fin_go;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    cmd          = '0;
    cmd.load     = in_valid && in_ready_r;
    cmd.prot     = (state_r == S_PROT);
    cmd.prep     = (state_r == S_PREP);
    cmd.div_step = (state_r == S_DIV);
    cmd.finish   = fin_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= S_PROT;
            in_ready_r <= 1'b0;
          end
        end
        S_PROT: begin
          state_r <= S_PREP;
        end
        S_PREP: begin
          state_r <= S_DIV;
          step_r  <= STEP_W'(DIV_STEPS);
        end
        S_DIV: begin
          step_r <= step_r - STEP_W'(1);
          if (step_r == STEP_W'(1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/fhtc_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fhtc_dp #(
  parameter int PWM_MAX = fhtc_pkg::PWM_MAX_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  fhtc_pkg::fhtc_cmd_t                 cmd,
  input  wire signed [fhtc_pkg::TEMP_W-1:0]   sensor_temp_a,
  input  wire signed [fhtc_pkg::TEMP_W-1:0]   sensor_temp_b,
  input  wire                                 system_active,
  input  wire                                 cfg_we,
  input  wire [fhtc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [fhtc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic [fhtc_pkg::LEVEL_W-1:0]        fan_level,
  output logic [fhtc_pkg::LEVEL_W-1:0]        heater_level,
  output logic                                over_temp
);

  localparam int PWMW = fhtc_pkg::pwm_width(PWM_MAX);
  localparam int NUMW = fhtc_pkg::div_width(PWM_MAX);
  localparam int ESW  = fhtc_pkg::sum_width(PWM_MAX);
  localparam int OW   = ESW + 5;
  localparam int LW   = fhtc_pkg::LEVEL_W;
  localparam int CW   = fhtc_pkg::CNT_W;

  // configuration
  logic signed [7:0]  fan_start_r;
  logic signed [7:0]  fan_full_r;
  logic signed [7:0]  target_r;
  logic               fan_en_r;
  logic               heat_en_r;
  logic               force_r;

  // control state
  logic [1:0]         smp_cnt_r;
  logic signed [7:0]  held_r;
  logic               active_r;
  logic [CW-1:0]      trip_r;
  logic [CW-1:0]      rel_r;
  logic               latch_r;
  logic               kick_r;
  logic [ESW-1:0]     esum_r;
  logic signed [9:0]  last_err_r;

  // working registers
  logic [7:0]         rem_r;
  logic [NUMW-1:0]    quo_r;
  logic [7:0]         den_r;
  logic [ESW-1:0]     pid_sum_r;
  logic [LW-1:0]      fan_r;
  logic [LW-1:0]      heat_r;
  logic               ot_r;

  // sample average, truncated toward zero
  logic signed [8:0]  pair_sum;
  logic signed [8:0]  pair_adj;
  logic signed [7:0]  pair_avg;

  // ramp endpoints
  logic               ramp_fallback;
  logic signed [7:0]  s_eff;
  logic signed [7:0]  f_eff;
  logic signed [8:0]  diff_ts;
  logic signed [8:0]  span;
  logic [NUMW-1:0]    ramp_prod;

  // divider step
  logic [8:0]         trial;
  logic [8:0]         trial_sub;
  logic               trial_ge;

  // over-temperature thresholds
  logic signed [8:0]  held_x;
  logic signed [8:0]  thr_set;
  logic signed [8:0]  thr_clr;
  logic [CW-1:0]      trip_inc;
  logic [CW-1:0]      rel_inc;

  // pid
  logic signed [9:0]      err;
  logic signed [ESW+1:0]  sum_w;
  logic [ESW-1:0]         sum_clamp;
  logic signed [OW-1:0]   err_x;
  logic signed [OW-1:0]   derr_x;
  logic signed [OW-1:0]   out2;
  logic [PWMW-1:0]        heat_pid;

  // fan
  logic [PWMW-1:0]    ramp_lvl;
  logic [PWMW-1:0]    fan_auto;
  logic [PWMW-1:0]    fan_kicked;
  logic [PWMW-1:0]    fan_lvl;
  logic [PWMW-1:0]    heat_lvl;
  logic               kick_nxt;
  logic [PWMW+LW-1:0] fan_ext;
  logic [PWMW+LW-1:0] heat_ext;

  always_comb begin
    pair_sum = {sensor_temp_a[7], sensor_temp_a} + {sensor_temp_b[7], sensor_temp_b};
    pair_adj = pair_sum + $signed({8'd0, pair_sum[8] & pair_sum[0]});
    pair_avg = pair_adj[8:1];
  end

  always_comb begin
    ramp_fallback = (fan_full_r <= fan_start_r);
    s_eff = ramp_fallback ? 8'(fhtc_pkg::RAMP_START_DEF) : fan_start_r;
    f_eff = ramp_fallback ? 8'(fhtc_pkg::RAMP_FULL_DEF)  : fan_full_r;
    diff_ts   = {held_r[7], held_r} - {s_eff[7], s_eff};
    span      = {f_eff[7], f_eff} - {s_eff[7], s_eff};
    ramp_prod = NUMW'(diff_ts[7:0]) * NUMW'(PWM_MAX);
  end

  always_comb begin
    trial     = {rem_r, quo_r[NUMW-1]};
    trial_sub = trial - {1'b0, den_r};
    trial_ge  = (trial >= {1'b0, den_r});
  end

  always_comb begin
    held_x   = {held_r[7], held_r};
    thr_set  = {target_r[7], target_r} + 9'sd8;
    thr_clr  = {target_r[7], target_r} + 9'sd5;
    trip_inc = trip_r + CW'(1);
    rel_inc  = rel_r + CW'(1);
  end

  always_comb begin
    err   = {{2{target_r[7]}}, target_r} - {{2{held_r[7]}}, held_r};
    sum_w = $signed({2'b00, esum_r}) + (ESW + 2)'(err);
    if (sum_w < 0) begin
      sum_clamp = '0;
    end else if (sum_w > $signed((ESW + 2)'(2 * PWM_MAX))) begin
      sum_clamp = ESW'(2 * PWM_MAX);
    end else begin
      sum_clamp = sum_w[ESW-1:0];
    end
    err_x  = OW'(err);
    derr_x = OW'(err) - OW'(last_err_r);
    out2   = err_x * $signed(OW'(fhtc_pkg::PID_KP2)) + $signed(OW'(pid_sum_r))
           + (derr_x <<< fhtc_pkg::PID_KD_SHIFT);
    if (out2 > $signed(OW'(2 * PWM_MAX))) begin
      heat_pid = PWMW'(PWM_MAX);
    end else if (out2 < 0) begin
      heat_pid = '0;
    end else begin
      heat_pid = out2[PWMW:1];
    end
  end

  always_comb begin
    if (held_r <= s_eff) begin
      ramp_lvl = '0;
    end else if (held_r >= f_eff) begin
      ramp_lvl = PWMW'(PWM_MAX);
    end else begin
      ramp_lvl = quo_r[PWMW-1:0];
    end
    fan_auto   = force_r ? PWMW'(PWM_MAX) : ramp_lvl;
    fan_kicked = fan_auto;
    kick_nxt   = kick_r;
    if (fan_auto != '0 && !kick_r) begin
      kick_nxt = 1'b1;
      if (fan_auto < PWMW'(fhtc_pkg::KICK_MIN)) begin
        fan_kicked = PWMW'(fhtc_pkg::KICK_MIN);
      end
    end else if (fan_auto == '0) begin
      kick_nxt = 1'b0;
    end

    fan_lvl  = '0;
    heat_lvl = '0;
    if (active_r) begin
      if (latch_r) begin
        fan_lvl = PWMW'(PWM_MAX);
      end else begin
        if (fan_en_r) begin
          fan_lvl = fan_kicked;
        end
        if (heat_en_r) begin
          heat_lvl = force_r ? PWMW'(PWM_MAX) : heat_pid;
        end
      end
    end
    fan_ext  = {{LW{1'b0}}, fan_lvl};
    heat_ext = {{LW{1'b0}}, heat_lvl};
  end

  // configuration and committed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_start_r <= 8'(fhtc_pkg::RAMP_START_DEF);
      fan_full_r  <= 8'(fhtc_pkg::RAMP_FULL_DEF);
      target_r    <= 8'(fhtc_pkg::HEAT_TARGET_DEF);
      fan_en_r    <= 1'b0;
      heat_en_r   <= 1'b0;
      force_r     <= 1'b0;
      smp_cnt_r   <= '0;
      held_r      <= '0;
      active_r    <= 1'b0;
      trip_r      <= '0;
      rel_r       <= '0;
      latch_r     <= 1'b0;
      kick_r      <= 1'b0;
      esum_r      <= '0;
      last_err_r  <= '0;
    end else begin
      if (cmd.load) begin
        active_r <= system_active;
        if (smp_cnt_r == 2'(fhtc_pkg::SAMPLE_LAST)) begin
          smp_cnt_r <= '0;
          held_r    <= pair_avg;
        end else begin
          smp_cnt_r <= smp_cnt_r + 2'd1;
        end
      end

      if (cmd.prot) begin
        if (!active_r) begin
          trip_r  <= '0;
          rel_r   <= '0;
          latch_r <= 1'b0;
        end else if (held_x >= thr_set) begin
          rel_r <= '0;
          if (!latch_r) begin
            if (trip_inc >= CW'(fhtc_pkg::OT_SET_TICKS)) begin
              trip_r  <= '0;
              latch_r <= 1'b1;
            end else begin
              trip_r <= trip_inc;
            end
          end
        end else if (held_x <= thr_clr) begin
          trip_r <= '0;
          if (latch_r) begin
            if (rel_inc >= CW'(fhtc_pkg::OT_CLR_TICKS)) begin
              rel_r   <= '0;
              latch_r <= 1'b0;
            end else begin
              rel_r <= rel_inc;
            end
          end
        end
      end

      if (cmd.finish && active_r) begin
        if (latch_r) begin
          esum_r     <= '0;
          last_err_r <= '0;
        end else begin
          if (fan_en_r) begin
            kick_r <= kick_nxt;
          end
          if (heat_en_r && !force_r) begin
            esum_r     <= pid_sum_r;
            last_err_r <= err;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          fhtc_pkg::CFG_FAN_TEMP_START: fan_start_r <= cfg_wdata;
          fhtc_pkg::CFG_FAN_TEMP_FULL:  fan_full_r  <= cfg_wdata;
          fhtc_pkg::CFG_HEAT_TARGET:    target_r    <= cfg_wdata;
          fhtc_pkg::CFG_FAN_ENABLE:     fan_en_r    <= cfg_wdata[0];
          fhtc_pkg::CFG_HEAT_ENABLE: begin
            heat_en_r <= cfg_wdata[0];
            if (!cfg_wdata[0]) begin
              esum_r     <= '0;
              last_err_r <= '0;
            end
          end
          fhtc_pkg::CFG_FORCE_FULL:     force_r     <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // divider, pid pre-sum and output register
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quo_r     <= ramp_prod;
      rem_r     <= '0;
      den_r     <= span[7:0];
      pid_sum_r <= sum_clamp;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_sub[7:0] : trial[7:0];
      quo_r <= {quo_r[NUMW-2:0], trial_ge};
    end
    if (cmd.finish) begin
      fan_r  <= fan_ext[LW-1:0];
      heat_r <= heat_ext[LW-1:0];
      ot_r   <= latch_r;
    end
  end

  assign fan_level    = fan_r;
  assign heater_level = heat_r;
  assign over_temp    = ot_r;

endmodule

`default_nettype wire

@@ src/fan_heater_thermal_controller_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake     payload
// in_ch     in   valid/ready   sensor_temp_a[8] sensor_temp_b[8] system_active[1]
// out_ch    out  valid/ready   fan_level[10] heater_level[10] over_temp[1]
// cfg       in   cfg_we only   cfg_index[3] cfg_wdata[8]
//
// one item in flight: an input transfer is followed by protection update, ramp
// setup, then one restoring divider step per cycle over div_width(PWM_MAX) bits
// (18 at the default) and a finish step; the serial ramp divider dominates the
// time an item takes; a result waiting in the output register only stalls the
// finish step, the next item is taken meanwhile
// rst_n is synchronous, active low; config and control state come out of reset

module fan_heater_thermal_controller_core #(
  parameter int PWM_MAX = fhtc_pkg::PWM_MAX_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  fhtc_in_if.sink                            in_ch,
  fhtc_out_if.source                         out_ch,
  input  wire                                cfg_we,
  input  wire [fhtc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [fhtc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // number of divider steps, one quotient bit each
  localparam int DIV_STEPS = fhtc_pkg::div_width(PWM_MAX);

  fhtc_pkg::fhtc_cmd_t cmd;

  // sequencer: owns the handshakes and issues at most one command per cycle
  fhtc_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath: config registers, held temp, latch, fan ramp divider, pid
  fhtc_dp #(
    .PWM_MAX (PWM_MAX)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sensor_temp_a (in_ch.sensor_temp_a),
    .sensor_temp_b (in_ch.sensor_temp_b),
    .system_active (in_ch.system_active),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fan_level     (out_ch.fan_level),
    .heater_level  (out_ch.heater_level),
    .over_temp     (out_ch.over_temp)
  );

endmodule

`default_nettype wire

@@ src/fhtc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "fan_heater_thermal_controller_core_defines.svh"

module fhtc_checker #(
  parameter int PWM_MAX = fhtc_pkg::PWM_MAX_DEF
) (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [fhtc_pkg::LEVEL_W-1:0]    fan_level,
  input wire [fhtc_pkg::LEVEL_W-1:0]    heater_level,
  input wire                            over_temp
);

  localparam logic [fhtc_pkg::LEVEL_W-1:0] FULL_LVL = fhtc_pkg::LEVEL_W'(PWM_MAX);
  localparam logic                         NARROW   = (PWM_MAX < 1024);

  // levels never pass full scale when full scale fits the field
  `FHTC_ASSERT_SAME(a_level_range, out_valid && NARROW, (fan_level <= FULL_LVL) && (heater_level <= FULL_LVL), "level above full scale")

  // latched protection runs the fan full and shuts the heater
  `FHTC_ASSERT_SAME(a_latch_levels, out_valid && over_temp, (heater_level == '0) && (fan_level == FULL_LVL), "protection levels wrong")

  // an input transfer closes the input until the item is done
  `FHTC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

  // a stalled result holds
  `FHTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fan_level) && $stable(heater_level) && $stable(over_temp), "stalled result changed")

endmodule

bind fan_heater_thermal_controller_core fhtc_checker #(
  .PWM_MAX (PWM_MAX)
) u_fhtc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .fan_level    (out_ch.fan_level),
  .heater_level (out_ch.heater_level),
  .over_temp    (out_ch.over_temp)
);

`default_nettype wire

@@ sim/tb_fan_heater_thermal_controller_core.sv @@
`timescale 1ns / 1ps

module tb_fan_heater_thermal_controller_core;

  localparam int PWM_MAX        = fhtc_pkg::PWM_MAX_DEF;
  localparam int GAP_MAX        = 18;
  localparam int RANDOM_TICKS   = 1200;
  localparam int SETTLE_CYCLES  = 66;    // settling wait past the last result
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
  // no register behind it
  localparam logic [fhtc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;

  typedef struct packed {
    logic [fhtc_pkg::LEVEL_W-1:0] fan;
    logic [fhtc_pkg::LEVEL_W-1:0] heat;
    logic                         ot;
  } levels_t;

  typedef enum logic {
    ROW_TICK,
    ROW_REG
  } row_kind_t;

  // one line of the directed plan: either a control tick or a register write
  typedef struct packed {
    row_kind_t                       kind;
    logic [fhtc_pkg::TEMP_W-1:0]     a;
    logic [fhtc_pkg::TEMP_W-1:0]     b;
    logic                            act;
    logic [fhtc_pkg::CFG_IDX_W-1:0]  idx;
    logic [fhtc_pkg::CFG_DATA_W-1:0] data;
    logic                            typed;  // expected levels written out by hand
    levels_t                         want;
  } plan_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [fhtc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fhtc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  fhtc_in_if  tick_if ();
  fhtc_out_if level_if ();

  fan_heater_thermal_controller_core #(
    .PWM_MAX(PWM_MAX)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (tick_if),
    .out_ch   (level_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow copy of the register file, reset values
  int   r_start  = fhtc_pkg::RAMP_START_DEF;
  int   r_full   = fhtc_pkg::RAMP_FULL_DEF;
  int   r_target = fhtc_pkg::HEAT_TARGET_DEF;
  logic r_fan_en = 1'b0;
  logic r_heat_en = 1'b0;
  logic r_force  = 1'b0;

  // shadow copy of the controller state
  int   div_cnt    = 0;
  int   held_t     = 0;
  int   trip_n     = 0;
  int   clear_n    = 0;
  logic ot_latched = 1'b0;
  logic kicked     = 1'b0;
  int   integ      = 0;
  int   prev_err   = 0;

  levels_t   levels_due[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        in_calm = 1'b0;
  bit        out_calm = 1'b0;

  function automatic void apply_reg(input logic [fhtc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [fhtc_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      fhtc_pkg::CFG_FAN_TEMP_START: r_start = int'($signed(val));
      fhtc_pkg::CFG_FAN_TEMP_FULL:  r_full = int'($signed(val));
      fhtc_pkg::CFG_HEAT_TARGET:    r_target = int'($signed(val));
      fhtc_pkg::CFG_FAN_ENABLE:     r_fan_en = val[0];
      fhtc_pkg::CFG_HEAT_ENABLE: begin
        r_heat_en = val[0];
        // turning the heater off drops the integral and derivative history
        if (!val[0]) begin
          integ = 0;
          prev_err = 0;
        end
      end
      fhtc_pkg::CFG_FORCE_FULL:     r_force = val[0];
      default: ;
    endcase
  endfunction

  // one control tick: advance the shadow state and return the three levels
  function automatic levels_t compute_levels(input logic signed [fhtc_pkg::TEMP_W-1:0] a,
                                             input logic signed [fhtc_pkg::TEMP_W-1:0] b,
                                             input logic act);
    levels_t r;
    int lo, hi, e, out2, fan, heat;
    fan = 0;
    heat = 0;

    // held temperature refreshes on every third tick, average truncates toward zero
    if (div_cnt == fhtc_pkg::SAMPLE_LAST) begin
      div_cnt = 0;
      held_t = (int'(a) + int'(b)) / 2;
    end else begin
      div_cnt++;
    end

    if (!act) begin
      // inactive tick shuts everything and drops the protection counters
      trip_n = 0;
      clear_n = 0;
      ot_latched = 1'b0;
    end else begin
      if (held_t >= r_target + fhtc_pkg::OT_SET_DELTA) begin
        clear_n = 0;
        if (!ot_latched) begin
          trip_n++;
          if (trip_n >= fhtc_pkg::OT_SET_TICKS) begin
            trip_n = 0;
            ot_latched = 1'b1;
          end
        end
      end else if (held_t <= r_target + fhtc_pkg::OT_CLR_DELTA) begin
        trip_n = 0;
        if (ot_latched) begin
          clear_n++;
          if (clear_n >= fhtc_pkg::OT_CLR_TICKS) begin
            clear_n = 0;
            ot_latched = 1'b0;
          end
        end
      end
      // between the two thresholds the counters hold

      if (ot_latched) begin
        fan = PWM_MAX;
      end else if (r_fan_en) begin
        if (r_force) begin
          fan = PWM_MAX;
        end else begin
          lo = r_start;
          hi = r_full;
          // unusable ramp falls back to the default pair
          if (hi <= lo) begin
            lo = fhtc_pkg::RAMP_START_DEF;
            hi = fhtc_pkg::RAMP_FULL_DEF;
          end
          if (held_t <= lo) fan = 0;
          else if (held_t >= hi) fan = PWM_MAX;
          else fan = (held_t - lo) * PWM_MAX / (hi - lo);
        end
        // first nonzero level after a stop gets at least the kick level
        if (fan > 0 && !kicked) begin
          kicked = 1'b1;
          if (fan < fhtc_pkg::KICK_MIN) fan = fhtc_pkg::KICK_MIN;
        end else if (fan == 0) begin
          kicked = 1'b0;
        end
      end

      if (ot_latched) begin
        integ = 0;
        prev_err = 0;
      end else if (r_heat_en) begin
        if (r_force) begin
          heat = PWM_MAX;
        end else begin
          e = r_target - held_t;
          integ += e;
          if (integ > 2 * PWM_MAX) integ = 2 * PWM_MAX;
          else if (integ < 0) integ = 0;
          // half units: kp 15 -> 30, ki 0.5 -> 1, kd 2 -> 4
          out2 = fhtc_pkg::PID_KP2 * e + integ + 4 * (e - prev_err);
          prev_err = e;
          if (out2 > 2 * PWM_MAX) heat = PWM_MAX;
          else if (out2 < 0) heat = 0;
          else heat = out2 / 2;
        end
      end
    end

    r.fan = fan[fhtc_pkg::LEVEL_W-1:0];
    r.heat = heat[fhtc_pkg::LEVEL_W-1:0];
    r.ot = ot_latched;
    return r;
  endfunction

  function automatic logic [fhtc_pkg::TEMP_W-1:0] to_temp(input int v);
    if (v > 127) v = 127;
    else if (v < -128) v = -128;
    return v[fhtc_pkg::TEMP_W-1:0];
  endfunction

  function automatic plan_row_t tick_row(input int a, input int b, input logic act);
    plan_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.a = a[fhtc_pkg::TEMP_W-1:0];
    r.b = b[fhtc_pkg::TEMP_W-1:0];
    r.act = act;
    return r;
  endfunction

  function automatic plan_row_t fixed_row(input int a, input int b, input logic act,
                                          input int fan, input int heat, input logic ot);
    plan_row_t r;
    r = tick_row(a, b, act);
    r.typed = 1'b1;
    r.want.fan = fan[fhtc_pkg::LEVEL_W-1:0];
    r.want.heat = heat[fhtc_pkg::LEVEL_W-1:0];
    r.want.ot = ot;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [fhtc_pkg::CFG_IDX_W-1:0] idx,
                                        input int val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = val[fhtc_pkg::CFG_DATA_W-1:0];
    return r;
  endfunction

  // register write, lands at the next rising edge
  task automatic write_reg(input logic [fhtc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fhtc_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  // hold the sender until every pending result has been taken
  task automatic wait_drained();
    tick_if.valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one tick transfer; valid stays up across back-to-back ticks
  task automatic push_tick(input logic [fhtc_pkg::TEMP_W-1:0] a,
                           input logic [fhtc_pkg::TEMP_W-1:0] b,
                           input logic act, input logic typed, input levels_t want);
    int gap;
    levels_t calc;
    gap = in_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_if.valid <= 1'b1;
    tick_if.sensor_temp_a <= a;
    tick_if.sensor_temp_b <= b;
    tick_if.system_active <= act;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    calc = compute_levels(a, b, act);
    levels_due.push_back(typed ? want : calc);
  endtask

  // result side: random stalls, every transfer checked against the oldest prediction
  initial begin : level_sink
    int stall;
    levels_t want;
    level_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        level_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      level_if.ready <= 1'b1;
      @(posedge clk);
      while (!level_if.valid) @(posedge clk);
      if (levels_due.size() == 0) begin
        $error("unexpected result: fan_level %0d heater_level %0d over_temp %0b",
               level_if.fan_level, level_if.heater_level, level_if.over_temp);
        mismatches++;
      end else begin
        want = levels_due.pop_front();
        if (level_if.fan_level !== want.fan) begin
          $error("fan_level: expected %0d, got %0d", want.fan, level_if.fan_level);
          mismatches++;
        end
        if (level_if.heater_level !== want.heat) begin
          $error("heater_level: expected %0d, got %0d", want.heat, level_if.heater_level);
          mismatches++;
        end
        if (level_if.over_temp !== want.ot) begin
          $error("over_temp: expected %0b, got %0b", want.ot, level_if.over_temp);
          mismatches++;
        end
      end
    end
  end

  // watchdog on transfers of either channel
  always @(posedge clk) begin
    if ((tick_if.valid && tick_if.ready) || (level_if.valid && level_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[fan_heater_thermal_controller_core] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t row;
    row_kind_t prev_kind;
    int        sent, phase_len, pick;
    int        lo, hi, tgt, center;
    logic [fhtc_pkg::TEMP_W-1:0] sa, sb;
    logic      act;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    tick_if.valid <= 1'b0;
    tick_if.sensor_temp_a <= '0;
    tick_if.sensor_temp_b <= '0;
    tick_if.system_active <= 1'b0;

    // reset values, both outputs disabled: only the latch can show
    plan.push_back(fixed_row(127, 127, 1'b1, 0, 0, 1'b0));
    plan.push_back(fixed_row(-128, -128, 1'b1, 0, 0, 1'b0));
    plan.push_back(fixed_row(127, 127, 1'b1, 0, 0, 1'b0));    // held 127, trip count starts
    plan.push_back(fixed_row(0, 0, 1'b1, 0, 0, 1'b0));
    plan.push_back(fixed_row(0, 0, 1'b1, 0, 0, 1'b0));
    plan.push_back(fixed_row(127, 126, 1'b1, 0, 0, 1'b0));    // refresh, still hot
    plan.push_back(fixed_row(0, 0, 1'b1, PWM_MAX, 0, 1'b1));  // fifth hot tick latches
    plan.push_back(fixed_row(-128, 127, 1'b0, 0, 0, 1'b0));   // inactive clears the latch
    plan.push_back(fixed_row(-128, -128, 1'b1, 0, 0, 1'b0));
    // both outputs on: cold tank, then a small ramp level that gets the kick
    plan.push_back(reg_row(fhtc_pkg::CFG_FAN_ENABLE, 1));
    plan.push_back(reg_row(fhtc_pkg::CFG_HEAT_ENABLE, 1));
    plan.push_back(tick_row(30, 31, 1'b1));
    plan.push_back(tick_row(30, 31, 1'b1));
    plan.push_back(tick_row(26, 27, 1'b1));
    plan.push_back(tick_row(27, 28, 1'b1));
    plan.push_back(tick_row(27, 28, 1'b1));
    plan.push_back(tick_row(27, 28, 1'b1));                   // no second kick
    // forced full, negative average truncating toward zero
    plan.push_back(reg_row(fhtc_pkg::CFG_FORCE_FULL, 1));
    plan.push_back(tick_row(-3, 0, 1'b1));
    plan.push_back(tick_row(-3, 0, 1'b1));
    plan.push_back(tick_row(-3, 0, 1'b1));
    // inverted ramp falls back to the defaults, held lands between thresholds
    plan.push_back(reg_row(fhtc_pkg::CFG_FORCE_FULL, 0));
    plan.push_back(reg_row(fhtc_pkg::CFG_FAN_TEMP_START, 127));
    plan.push_back(reg_row(fhtc_pkg::CFG_FAN_TEMP_FULL, -128));
    plan.push_back(tick_row(39, 40, 1'b1));
    plan.push_back(tick_row(39, 40, 1'b1));
    plan.push_back(tick_row(32, 33, 1'b1));
    // write to a hole in the map is dropped, heater off clears the pid history
    plan.push_back(reg_row(CFG_IDX_SPARE, 255));
    plan.push_back(reg_row(fhtc_pkg::CFG_HEAT_ENABLE, 0));
    plan.push_back(tick_row(-128, 127, 1'b1));
    plan.push_back(tick_row(-128, 127, 1'b1));
    plan.push_back(tick_row(127, 127, 1'b0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed plan
    prev_kind = ROW_TICK;
    foreach (plan[k]) begin
      row = plan[k];
      if (row.kind == ROW_REG) begin
        if (prev_kind != ROW_REG) wait_drained();
        write_reg(row.idx, row.data);
      end else begin
        if (prev_kind == ROW_REG) cfg_we <= 1'b0;
        push_tick(row.a, row.b, row.act, row.typed, row.want);
      end
      prev_kind = row.kind;
    end

    // random phases: new register set on an idle block, then a run of ticks
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      wait_drained();
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);

      case ($urandom_range(0, 3))
        0: begin
          lo = int'($urandom_range(0, 255)) - 128;
          hi = int'($urandom_range(0, 255)) - 128;
        end
        1: begin
          // widest ramp
          lo = -128;
          hi = 127;
        end
        2: begin
          lo = $urandom_range(0, 60);
          hi = lo + int'($urandom_range(1, 30));
        end
        default: begin
          // full not above start
          hi = int'($urandom_range(0, 100)) - 50;
          lo = hi + int'($urandom_range(0, 50));
        end
      endcase
      pick = $urandom_range(0, 19);
      if (pick == 0) tgt = -128;
      else if (pick == 1) tgt = 127;
      else if (pick < 4) tgt = int'($urandom_range(0, 255)) - 128;
      else tgt = $urandom_range(10, 50);

      write_reg(fhtc_pkg::CFG_FAN_TEMP_START, lo[fhtc_pkg::CFG_DATA_W-1:0]);
      write_reg(fhtc_pkg::CFG_FAN_TEMP_FULL, hi[fhtc_pkg::CFG_DATA_W-1:0]);
      write_reg(fhtc_pkg::CFG_HEAT_TARGET, tgt[fhtc_pkg::CFG_DATA_W-1:0]);
      write_reg(fhtc_pkg::CFG_FAN_ENABLE,
                fhtc_pkg::CFG_DATA_W'($urandom_range(0, 4) != 0));
      write_reg(fhtc_pkg::CFG_HEAT_ENABLE,
                fhtc_pkg::CFG_DATA_W'($urandom_range(0, 4) != 0));
      write_reg(fhtc_pkg::CFG_FORCE_FULL,
                fhtc_pkg::CFG_DATA_W'($urandom_range(0, 6) == 0));
      if ($urandom_range(0, 4) == 0) begin
        write_reg(CFG_IDX_SPARE, fhtc_pkg::CFG_DATA_W'($urandom_range(0, 255)));
      end
      cfg_we <= 1'b0;

      // tank temperature wanders slowly around the setpoint so the latch
      // sees full set and release runs; a few ticks are pure noise
      center = tgt + int'($urandom_range(0, 25)) - 10;
      phase_len = $urandom_range(20, 100);
      repeat (phase_len) begin
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
          sa = fhtc_pkg::TEMP_W'($urandom);
          sb = fhtc_pkg::TEMP_W'($urandom);
          act = 1'($urandom);
        end else begin
          pick = $urandom_range(0, 23);
          if (pick == 0) center = tgt + int'($urandom_range(0, 16)) - 4;
          else if (pick == 1) center = lo + int'($urandom_range(0, 40)) - 5;
          else center = center + int'($urandom_range(0, 4)) - 2;
          if (center > 127) center = 127;
          else if (center < -128) center = -128;
          sa = to_temp(center + int'($urandom_range(0, 6)) - 3);
          sb = to_temp(center + int'($urandom_range(0, 6)) - 3);
          act = ($urandom_range(0, 29) != 0);
        end
        push_tick(sa, sb, act, 1'b0, '0);
        sent++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[fan_heater_thermal_controller_core] OK");
    end else begin
      $display("[fan_heater_thermal_controller_core] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/fhtc_pkg.sv
src/fhtc_if.sv
src/fhtc_ctrl.sv
src/fhtc_dp.sv
src/fan_heater_thermal_controller_core.sv
src/fhtc_checker.sv
sim/tb_fan_heater_thermal_controller_core.sv
